@@ sv/ctb_pkg.sv @@
// Shared types, codes and constants for the countdown timer bank.
package ctb_pkg;

    localparam int DEF_NUM_TIMERS = 16;
    localparam int CMD_W          = 3;
    localparam int ID_W           = 8;
    localparam int DUR_W          = 32;
    localparam int SLOT_W         = 4;
    localparam int MASK_W         = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_UPDATE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_START,
        S_DONE
    } t_state;

    // write side of the timer memory
    typedef struct packed {
        logic             dur_we;
        logic             rem_we;
        logic [DUR_W-1:0] dur_wdata;
        logic [DUR_W-1:0] rem_wdata;
    } t_mem_wr;

    // one result word
    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot_used;
        logic [MASK_W-1:0] expired_mask;
        logic [MASK_W-1:0] active_mask;
    } t_result;

endpackage

@@ sv/ctb_if.sv @@
// Valid/ready channel interfaces for command and result words.
interface ctb_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ctb_pkg::CMD_W-1:0]    command;
    logic [ctb_pkg::ID_W-1:0]     timer_id;
    logic [ctb_pkg::DUR_W-1:0]    duration_ticks;
    logic                         auto_start;

    modport source (output valid, command, timer_id, duration_ticks, auto_start,
                    input ready);
    modport sink   (input valid, command, timer_id, duration_ticks, auto_start,
                    output ready);
endinterface

interface ctb_res_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [ctb_pkg::SLOT_W-1:0]   slot_used;
    logic [ctb_pkg::MASK_W-1:0]   expired_mask;
    logic [ctb_pkg::MASK_W-1:0]   active_mask;

    modport source (output valid, accepted, slot_used, expired_mask, active_mask,
                    input ready);
    modport sink   (input valid, accepted, slot_used, expired_mask, active_mask,
                    output ready);
endinterface

@@ sv/countdown_timer_bank_top.sv @@
// Countdown timer bank: sequencer, timer memory and result output register.
// A tick walks the remaining-count memory at one entry per cycle through its read port;
//   start reads the stored duration first; add, stop, update and unknown codes go straight to the result.
// Throughput: one command at a time; the sequencer takes no new command until the
//   result word of the last one has been pushed to the output register.
// Reset: synchronous active-low; clears all active flags and marks every stored
//   duration as zero at once, so no clearing pass is needed.
module countdown_timer_bank_top #(
    parameter int NUM_TIMERS = ctb_pkg::DEF_NUM_TIMERS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ctb_cmd_if.sink        i_cmd,
    ctb_res_if.source      o_res
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // sequencer <-> memory
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    ctb_pkg::t_mem_wr          mem_wr;
    logic [ctb_pkg::DUR_W-1:0] rd_dur;
    logic [ctb_pkg::DUR_W-1:0] rd_rem;

    // sequencer -> output register
    logic                      push;
    logic                      out_space;
    ctb_pkg::t_result          result;

    // one-word output register: the sequencer may take the next command
    // while this word still waits for the sink
    logic                      r_out_vld;
    ctb_pkg::t_result          r_out;

    assign out_space = !r_out_vld || o_res.ready;

    ctb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_cmd.valid),
        .o_in_ready       (i_cmd.ready),
        .i_command        (i_cmd.command),
        .i_timer_id       (i_cmd.timer_id),
        .i_duration_ticks (i_cmd.duration_ticks),
        .i_auto_start     (i_cmd.auto_start),
        .i_out_space      (out_space),
        .o_push           (push),
        .o_result         (result),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .o_wr_addr        (wr_addr),
        .o_wr             (mem_wr),
        .i_rd_dur         (rd_dur),
        .i_rd_rem         (rd_rem)
    );

    ctb_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr      (mem_wr),
        .o_rd_dur  (rd_dur),
        .o_rd_rem  (rd_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.accepted     = r_out.accepted;
    assign o_res.slot_used    = r_out.slot_used;
    assign o_res.expired_mask = r_out.expired_mask;
    assign o_res.active_mask  = r_out.active_mask;

endmodule

@@ sv/ctb_mem.sv @@
// Duration and remaining-count memories with registered read, one port each way.
module ctb_mem #(
    parameter int NUM_TIMERS = ctb_pkg::DEF_NUM_TIMERS,
    parameter int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    input  logic [AW-1:0]             i_wr_addr,
    input  ctb_pkg::t_mem_wr          i_wr,
    output logic [ctb_pkg::DUR_W-1:0] o_rd_dur,
    output logic [ctb_pkg::DUR_W-1:0] o_rd_rem
);

    logic [ctb_pkg::DUR_W-1:0] dur_mem [NUM_TIMERS];
    logic [ctb_pkg::DUR_W-1:0] rem_mem [NUM_TIMERS];

    logic [NUM_TIMERS-1:0]     r_dur_vld;   // duration reads as zero until written
    logic [ctb_pkg::DUR_W-1:0] r_rd_dur;
    logic [ctb_pkg::DUR_W-1:0] r_rd_rem;
    logic                      r_rd_dv;

    always_ff @(posedge i_clk) begin
        if (i_wr.dur_we) begin
            dur_mem[i_wr_addr] <= i_wr.dur_wdata;
        end
        if (i_wr.rem_we) begin
            rem_mem[i_wr_addr] <= i_wr.rem_wdata;
        end
        if (i_rd_en) begin
            r_rd_dur <= dur_mem[i_rd_addr];
            r_rd_rem <= rem_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur_vld <= '0;
            r_rd_dv   <= 1'b0;
        end else begin
            if (i_wr.dur_we) begin
                r_dur_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_dv <= r_dur_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_dur = r_rd_dv ? r_rd_dur : '0;
    assign o_rd_rem = r_rd_rem;

endmodule

@@ sv/ctb_ctrl.sv @@
// Command sequencer: decodes a command, walks the memory on tick, keeps active flags.
module ctb_ctrl #(
    parameter int NUM_TIMERS = ctb_pkg::DEF_NUM_TIMERS,
    parameter int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ctb_pkg::CMD_W-1:0]  i_command,
    input  logic [ctb_pkg::ID_W-1:0]   i_timer_id,
    input  logic [ctb_pkg::DUR_W-1:0]  i_duration_ticks,
    input  logic                       i_auto_start,
    input  logic                       i_out_space,
    output logic                       o_push,
    output ctb_pkg::t_result           o_result,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    output logic [AW-1:0]              o_wr_addr,
    output ctb_pkg::t_mem_wr           o_wr,
    input  logic [ctb_pkg::DUR_W-1:0]  i_rd_dur,
    input  logic [ctb_pkg::DUR_W-1:0]  i_rd_rem
);

    ctb_pkg::t_state r_state, n_state;

    logic [ctb_pkg::CMD_W-1:0]  r_cmd;
    logic [ctb_pkg::ID_W-1:0]   r_id;
    logic [ctb_pkg::DUR_W-1:0]  r_dur;
    logic                       r_auto;
    logic [NUM_TIMERS-1:0]      r_active;
    logic [AW:0]                r_idx;
    logic                       r_proc_vld;
    logic [AW-1:0]              r_proc_idx;
    logic                       r_accepted;
    logic [ctb_pkg::SLOT_W-1:0] r_slot;
    logic [ctb_pkg::MASK_W-1:0] r_expired;

    logic                       id_ok;
    logic [AW-1:0]              id_idx;
    logic [NUM_TIMERS-1:0]      free_oh;
    logic                       free_found;
    logic [AW-1:0]              free_idx;
    logic [ctb_pkg::SLOT_W-1:0] free_slot;
    logic                       walk_rd;
    logic                       proc_hit;
    logic                       proc_exp;
    logic [ctb_pkg::MASK_W-1:0] act_mask;

    assign id_ok  = r_id < ctb_pkg::ID_W'(NUM_TIMERS);
    assign id_idx = r_id[AW-1:0];

    // lowest clear flag: one-hot of ~a & (a + 1)
    assign free_oh    = ~r_active & (r_active + NUM_TIMERS'(1));
    assign free_found = ~&r_active;

    always_comb begin
        free_idx  = '0;
        free_slot = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (free_oh[i]) begin
                free_idx  = free_idx | AW'(i);
                free_slot = free_slot | ctb_pkg::SLOT_W'(i);
            end
        end
    end

    assign walk_rd  = (r_state == ctb_pkg::S_TICK) && (r_idx < (AW+1)'(NUM_TIMERS));
    assign proc_hit = r_proc_vld && r_active[r_proc_idx] && (i_rd_rem != '0);
    assign proc_exp = proc_hit && (i_rd_rem == ctb_pkg::DUR_W'(1));

    for (genvar j = 0; j < ctb_pkg::MASK_W; j++) begin : g_mask
        if (j < NUM_TIMERS) begin : g_on
            assign act_mask[j] = r_active[j];
        end else begin : g_off
            assign act_mask[j] = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctb_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ctb_pkg::S_EXEC;
            end
            ctb_pkg::S_EXEC: begin
                if (r_cmd == ctb_pkg::CMD_TICK) begin
                    n_state = ctb_pkg::S_TICK;
                end else if (r_cmd == ctb_pkg::CMD_START && id_ok) begin
                    n_state = ctb_pkg::S_START;
                end else begin
                    n_state = ctb_pkg::S_DONE;
                end
            end
            ctb_pkg::S_TICK: begin
                if (r_idx == (AW+1)'(NUM_TIMERS)) n_state = ctb_pkg::S_DONE;
            end
            ctb_pkg::S_START: n_state = ctb_pkg::S_DONE;
            ctb_pkg::S_DONE: begin
                if (i_out_space) n_state = ctb_pkg::S_IDLE;
            end
            default: n_state = ctb_pkg::S_IDLE;
        endcase
    end

    // outputs: handshake and memory access
    always_comb begin
        o_in_ready   = 1'b0;
        o_push       = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_idx[AW-1:0];
        o_wr_addr    = r_proc_idx;
        o_wr         = '0;
        o_wr.dur_wdata = r_dur;
        o_wr.rem_wdata = r_dur;
        unique case (r_state)
            ctb_pkg::S_IDLE: o_in_ready = 1'b1;
            ctb_pkg::S_EXEC: begin
                if (r_cmd == ctb_pkg::CMD_ADD && free_found) begin
                    o_wr_addr   = free_idx;
                    o_wr.dur_we = 1'b1;
                    o_wr.rem_we = 1'b1;
                end else if (r_cmd == ctb_pkg::CMD_UPDATE && id_ok) begin
                    o_wr_addr   = id_idx;
                    o_wr.dur_we = 1'b1;
                    o_wr.rem_we = r_active[id_idx];
                end else if (r_cmd == ctb_pkg::CMD_START && id_ok) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = id_idx;
                end
            end
            ctb_pkg::S_TICK: begin
                o_rd_en        = walk_rd;
                o_wr_addr      = r_proc_idx;
                o_wr.rem_we    = proc_hit;
                o_wr.rem_wdata = i_rd_rem - ctb_pkg::DUR_W'(1);
            end
            ctb_pkg::S_START: begin
                o_wr_addr      = id_idx;
                o_wr.rem_we    = 1'b1;
                o_wr.rem_wdata = i_rd_dur;
            end
            ctb_pkg::S_DONE: o_push = i_out_space;
            default: ;
        endcase
    end

    assign o_result.accepted     = r_accepted;
    assign o_result.slot_used    = r_slot;
    assign o_result.expired_mask = r_expired;
    assign o_result.active_mask  = act_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ctb_pkg::S_IDLE;
            r_active   <= '0;
            r_proc_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_proc_vld <= walk_rd;
            case (r_state)
                ctb_pkg::S_EXEC: begin
                    r_idx <= '0;
                    if (r_cmd == ctb_pkg::CMD_ADD && free_found) begin
                        r_active[free_idx] <= r_auto;
                    end else if (r_cmd == ctb_pkg::CMD_STOP && id_ok) begin
                        r_active[id_idx] <= 1'b0;
                    end
                end
                ctb_pkg::S_TICK: begin
                    if (walk_rd) r_idx <= r_idx + (AW+1)'(1);
                    if (proc_exp) r_active[r_proc_idx] <= 1'b0;
                end
                ctb_pkg::S_START: r_active[id_idx] <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload and result registers
    always_ff @(posedge i_clk) begin
        r_proc_idx <= r_idx[AW-1:0];
        case (r_state)
            ctb_pkg::S_IDLE: begin
                r_cmd      <= i_command;
                r_id       <= i_timer_id;
                r_dur      <= i_duration_ticks;
                r_auto     <= i_auto_start;
                r_accepted <= 1'b0;
                r_slot     <= '0;
                r_expired  <= '0;
            end
            ctb_pkg::S_EXEC: begin
                if (r_cmd == ctb_pkg::CMD_TICK) begin
                    r_accepted <= 1'b1;
                end else if (r_cmd == ctb_pkg::CMD_ADD) begin
                    if (free_found) begin
                        r_accepted <= 1'b1;
                        r_slot     <= free_slot;
                    end
                end else if (r_cmd == ctb_pkg::CMD_START || r_cmd == ctb_pkg::CMD_STOP ||
                             r_cmd == ctb_pkg::CMD_UPDATE) begin
                    r_accepted <= id_ok;
                end
            end
            ctb_pkg::S_TICK: begin
                for (int j = 0; j < ctb_pkg::MASK_W; j++) begin
                    if (proc_exp && j < NUM_TIMERS && r_proc_idx == AW'(j)) begin
                        r_expired[j] <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ sv/ctb_checker.sv @@
// Port-level checker for the timer bank, bound to the top level.
module ctb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_accepted,
    input logic [ctb_pkg::SLOT_W-1:0]  i_slot_used,
    input logic [ctb_pkg::MASK_W-1:0]  i_expired_mask,
    input logic [ctb_pkg::MASK_W-1:0]  i_active_mask
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_accepted) &&
        $stable(i_slot_used) && $stable(i_expired_mask) && $stable(i_active_mask))
        else $error("result word changed while stalled");

    // one command in flight: ready drops right after acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command taken while one is in flight");

    // an expired timer is inactive in the same word
    a_expired_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_expired_mask & i_active_mask) == '0)
        else $error("expired timer still shown active");

    // expiry or a nonzero slot only comes with an accepted command
    a_flags_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_expired_mask != '0 || i_slot_used != '0) |-> i_accepted)
        else $error("expiry or slot reported on rejected command");

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind countdown_timer_bank_top ctb_checker u_ctb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_accepted     (o_res.accepted),
    .i_slot_used    (o_res.slot_used),
    .i_expired_mask (o_res.expired_mask),
    .i_active_mask  (o_res.active_mask)
);
